// ===== rtl/crank_nicolson_jacobi_step_defines.svh =====
// assertion macros used by the crank-nicolson step controller
`ifndef CRANK_NICOLSON_JACOBI_STEP_DEFINES_SVH
`define CRANK_NICOLSON_JACOBI_STEP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CNJS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cnjs check failed");

// next-cycle implication, sampled on clk, off during reset
`define CNJS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cnjs check failed");

`endif

// ===== rtl/cnjs_pkg.sv =====
// shared types, constants and helpers of the crank-nicolson step block
package cnjs_pkg;

  localparam int POINTS = 128;
  localparam int AW     = 7;
  localparam int SW     = 24;
  localparam int CW     = 24;
  localparam int FRAC   = 20;
  localparam int CFRAC  = 16;
  localparam int NUMW   = 62;
  localparam int DENW   = 49;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 24;
  localparam int SWPW   = 8;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_SOLVE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [CFG_IW-1:0] CFG_SPACE_STEP_SQ = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_TIME_COEF     = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_SWEEP_COUNT   = 2'd2;

  localparam logic [CW-1:0]   RST_SPACE_STEP_SQ = 24'd65536;
  localparam logic [CW-1:0]   RST_TIME_COEF     = 24'd13107200;
  localparam logic [SWPW-1:0] RST_SWEEP_COUNT   = 8'd20;

  typedef logic signed [SW-1:0] sample_t;

  typedef struct packed {
    logic [1:0]           command;
    logic [AW-1:0]        point_index;
    logic signed [CW-1:0] potential;
    sample_t              wave_re;
    sample_t              wave_im;
  } in_item_t;

  typedef struct packed {
    logic          kind;
    logic [AW-1:0] out_index;
    sample_t       new_re;
    sample_t       new_im;
    logic [SW-1:0] density;
  } out_item_t;

  typedef struct packed {
    logic [AW-1:0] addr;
    logic          ld_we;
    logic          copy_rd;
    logic          cap_c;
    logic          cap_m;
    logic          cap_p;
    logic          calc_w;
    logic          mul_n;
    logic          sum_n;
    logic          div_start;
    logic          it_we;
    logic          left_clr;
    logic          rd_sq;
    logic          out_ld_done;
    logic          out_ld_read;
  } cmd_t;

  typedef struct packed {
    logic            div_done;
    logic            out_free;
    logic [SWPW-1:0] sweep_count;
  } stat_t;

  // clamp a wide diagonal term to a signed coefficient
  function automatic logic signed [CW-1:0] sat_coef(input logic signed [34:0] v);
    logic signed [34:0] hi;
    logic signed [34:0] lo;
    hi = 35'sd8388607;
    lo = -35'sd8388608;
    if (v > hi) begin
      return {1'b0, {(CW-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return v[CW-1:0];
    end
  endfunction

endpackage

// ===== rtl/cnjs_div.sv =====
// restoring divider: scaled, truncated, saturating quotient of the update
module cnjs_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [cnjs_pkg::NUMW-1:0] num,
  input  logic [cnjs_pkg::DENW-1:0]     den,
  output cnjs_pkg::sample_t             quo,
  output logic                          done
);
  import cnjs_pkg::*;

  localparam int QW   = SW - 1;
  localparam int MW   = NUMW - 1;
  localparam int RW   = MW + CFRAC;
  localparam int DSW  = DENW + QW - 1;
  localparam int INTB = QW - CFRAC;
  localparam int CNTW = $clog2(QW + 1);

  logic            busy_r, done_r;
  logic [CNTW-1:0] cnt_r;
  logic [RW-1:0]   rem_r;
  logic [DSW-1:0]  dsh_r;
  logic [QW-1:0]   q_r;
  logic            neg_r, sat_r, zero_r;

  logic [NUMW-1:0] num_neg;
  logic [MW-1:0]   mag;
  logic [RW-1:0]   dsh_ext;
  logic [SW-1:0]   q_ext;

  assign num_neg = -num;
  assign mag     = num[NUMW-1] ? num_neg[MW-1:0] : num[MW-1:0];
  assign dsh_ext = RW'(dsh_r);
  assign q_ext   = SW'(q_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNTW'(QW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {mag, {CFRAC{1'b0}}};
      dsh_r  <= {den, {(QW-1){1'b0}}};
      q_r    <= '0;
      neg_r  <= num[NUMW-1];
      zero_r <= (den == '0);
      // integer part of the quotient would not fit
      sat_r  <= (mag >= MW'({den, {INTB{1'b0}}}));
    end else if (busy_r) begin
      if (rem_r >= dsh_ext) begin
        rem_r <= rem_r - dsh_ext;
        q_r   <= {q_r[QW-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[QW-2:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
    end
  end

  always_comb begin
    if (zero_r) begin
      quo = '0;
    end else if (sat_r) begin
      quo = neg_r ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      quo = neg_r ? -q_ext : q_ext;
    end
  end

  assign done = done_r;

endmodule

// ===== rtl/cnjs_dp.sv =====
// datapath: point memories, update arithmetic, read-back and result register
module cnjs_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cnjs_pkg::cmd_t                 cmd,
  output cnjs_pkg::stat_t                stat,
  input  cnjs_pkg::in_item_t             in_data,
  input  logic                           cfg_we,
  input  logic [cnjs_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [cnjs_pkg::CFG_DW-1:0]    cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output cnjs_pkg::out_item_t            out_data
);
  import cnjs_pkg::*;

  localparam logic signed [34:0] TWO = 35'sd131072;

  // configuration
  logic [CW-1:0]   h_r, ci_r;
  logic [SWPW-1:0] swc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r   <= RST_SPACE_STEP_SQ;
      ci_r  <= RST_TIME_COEF;
      swc_r <= RST_SWEEP_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPACE_STEP_SQ: h_r   <= cfg_data[CW-1:0];
        CFG_TIME_COEF:     ci_r  <= cfg_data[CW-1:0];
        CFG_SWEEP_COUNT:   swc_r <= cfg_data[SWPW-1:0];
        default: ;
      endcase
    end
  end

  // memories: potential, and wave and iterate stored as {re, im}
  logic signed [CW-1:0] pot_mem [POINTS];
  logic [2*SW-1:0]      st_mem  [POINTS];
  logic [2*SW-1:0]      it_mem  [POINTS];

  logic signed [CW-1:0] pot_q;
  logic [2*SW-1:0]      st_q, it_q;
  logic [AW-1:0]        addr_r;
  logic                 copy_pend_r;
  sample_t              div_re, div_im;
  logic                 done_re, done_im;

  always_ff @(posedge clk) begin
    if (cmd.ld_we) begin
      pot_mem[cmd.addr] <= in_data.potential;
      st_mem[cmd.addr]  <= {in_data.wave_re, in_data.wave_im};
    end
    pot_q  <= pot_mem[cmd.addr];
    st_q   <= st_mem[cmd.addr];
    addr_r <= cmd.addr;
  end

  // end points read as zero
  logic    edge_pt;
  sample_t st_re, st_im, it_re, it_im;

  assign edge_pt = (addr_r == '0) || (addr_r == AW'(POINTS - 1));
  assign st_re   = edge_pt ? '0 : st_q[2*SW-1:SW];
  assign st_im   = edge_pt ? '0 : st_q[SW-1:0];
  assign it_re   = edge_pt ? '0 : it_q[2*SW-1:SW];
  assign it_im   = edge_pt ? '0 : it_q[SW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      copy_pend_r <= 1'b0;
    end else begin
      copy_pend_r <= cmd.copy_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (copy_pend_r) begin
      it_mem[addr_r] <= {st_re, st_im};
    end else if (cmd.it_we) begin
      it_mem[cmd.addr] <= {div_re, div_im};
    end
    it_q <= it_mem[cmd.addr];
  end

  // point update pipeline
  logic signed [CW:0]    ci25;
  sample_t               psi_c_re, psi_c_im, old_c_re, old_c_im;
  sample_t               psi_m_re, psi_m_im, psi_p_re, psi_p_im;
  sample_t               it_p_re, it_p_im, left_re_r, left_im_r;
  logic signed [48:0]    sprod_r;
  logic signed [34:0]    s35;
  logic signed [CW-1:0]  ar_r, br_r;
  logic signed [48:0]    m1_r, m2_r, m3_r, m4_r;
  logic signed [47:0]    aa_r;
  logic [47:0]           cc_r;
  logic signed [49:0]    t_re, t_im;
  logic signed [35:0]    nr_r, ni_r;
  logic [DENW-1:0]       den_r;
  logic signed [60:0]    p1_r, p2_r, p3_r, p4_r;
  logic signed [NUMW-1:0] num_re_r, num_im_r;

  assign ci25 = $signed({1'b0, ci_r});
  assign s35  = 35'($signed(sprod_r[48:CFRAC]));
  assign t_re = 50'(m1_r) - 50'(m2_r);
  assign t_im = 50'(m3_r) + 50'(m4_r);

  always_ff @(posedge clk) begin
    if (cmd.cap_c) begin
      psi_c_re <= st_re;
      psi_c_im <= st_im;
      old_c_re <= it_re;
      old_c_im <= it_im;
      sprod_r  <= $signed({1'b0, h_r}) * pot_q;
    end
    if (cmd.cap_m) begin
      psi_m_re <= st_re;
      psi_m_im <= st_im;
      ar_r     <= sat_coef(-s35 - TWO);
      br_r     <= sat_coef(s35 + TWO);
    end
    if (cmd.cap_p) begin
      psi_p_re <= st_re;
      psi_p_im <= st_im;
      it_p_re  <= it_re;
      it_p_im  <= it_im;
      m1_r     <= 49'(br_r * psi_c_re);
      m2_r     <= ci25 * psi_c_im;
      m3_r     <= 49'(br_r * psi_c_im);
      m4_r     <= ci25 * psi_c_re;
      aa_r     <= ar_r * ar_r;
      cc_r     <= ci_r * ci_r;
    end
    if (cmd.calc_w) begin
      nr_r  <= 36'($signed(t_re[49:CFRAC])) - 36'(psi_m_re) - 36'(psi_p_re)
             - 36'(left_re_r) - 36'(it_p_re);
      ni_r  <= 36'($signed(t_im[49:CFRAC])) - 36'(psi_m_im) - 36'(psi_p_im)
             - 36'(left_im_r) - 36'(it_p_im);
      den_r <= DENW'(aa_r[46:0]) + DENW'(cc_r);
    end
    if (cmd.mul_n) begin
      p1_r <= 61'(nr_r * ar_r);
      p2_r <= ni_r * ci25;
      p3_r <= 61'(ni_r * ar_r);
      p4_r <= nr_r * ci25;
    end
    if (cmd.sum_n) begin
      num_re_r <= NUMW'(p1_r) + NUMW'(p2_r);
      num_im_r <= NUMW'(p3_r) - NUMW'(p4_r);
    end
  end

  // left neighbour from the iterate before this sweep
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.left_clr) begin
      left_re_r <= '0;
      left_im_r <= '0;
    end else if (cmd.it_we) begin
      left_re_r <= old_c_re;
      left_im_r <= old_c_im;
    end
  end

  cnjs_div u_div_re (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_re_r),
    .den   (den_r),
    .quo   (div_re),
    .done  (done_re)
  );

  cnjs_div u_div_im (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (num_im_r),
    .den   (den_r),
    .quo   (div_im),
    .done  (done_im)
  );

  // read-back
  logic signed [47:0] sq_re_r, sq_im_r;
  sample_t            rd_re_r, rd_im_r;
  logic [AW-1:0]      rd_idx_r;
  logic [47:0]        sq_sum;
  logic [27:0]        dens_w;
  logic [SW-1:0]      dens;

  always_ff @(posedge clk) begin
    if (cmd.rd_sq) begin
      sq_re_r  <= it_re * it_re;
      sq_im_r  <= it_im * it_im;
      rd_re_r  <= it_re;
      rd_im_r  <= it_im;
      rd_idx_r <= addr_r;
    end
  end

  assign sq_sum = 48'(sq_re_r[46:0]) + 48'(sq_im_r[46:0]);
  assign dens_w = sq_sum[47:FRAC];
  assign dens   = (|dens_w[27:SW]) ? '1 : dens_w[SW-1:0];

  // result register
  logic      out_valid_r;
  out_item_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld_done || cmd.out_ld_read) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld_done) begin
      out_r <= '{kind: KIND_DONE, out_index: '0, new_re: '0, new_im: '0, density: '0};
    end else if (cmd.out_ld_read) begin
      out_r <= '{kind: KIND_READ, out_index: rd_idx_r, new_re: rd_re_r,
                 new_im: rd_im_r, density: dens};
    end
  end

  assign out_valid        = out_valid_r;
  assign out_data         = out_r;
  assign stat.div_done    = done_re & done_im;
  assign stat.out_free    = !out_valid_r || out_ready;
  assign stat.sweep_count = swc_r;

endmodule

// ===== rtl/cnjs_ctrl.sv =====
// controller: command decode, copy pass, sweep and point sequencing
`include "crank_nicolson_jacobi_step_defines.svh"

module cnjs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cnjs_pkg::in_item_t in_data,
  input  cnjs_pkg::stat_t    stat,
  output cnjs_pkg::cmd_t     cmd
);
  import cnjs_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_COPY = 4'd1;
  localparam logic [3:0] S_PA   = 4'd2;
  localparam logic [3:0] S_PB   = 4'd3;
  localparam logic [3:0] S_PC   = 4'd4;
  localparam logic [3:0] S_PD   = 4'd5;
  localparam logic [3:0] S_PE   = 4'd6;
  localparam logic [3:0] S_PF   = 4'd7;
  localparam logic [3:0] S_PG   = 4'd8;
  localparam logic [3:0] S_PH   = 4'd9;
  localparam logic [3:0] S_DIV  = 4'd10;
  localparam logic [3:0] S_WR   = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;
  localparam logic [3:0] S_R1   = 4'd13;
  localparam logic [3:0] S_R2   = 4'd14;

  localparam logic [AW-1:0] PT_LAST = AW'(POINTS - 1);
  localparam logic [AW-1:0] PT_END  = AW'(POINTS - 2);

  logic [3:0]      state_r, state_nxt;
  logic [AW-1:0]   pt_r, pt_nxt;
  logic [SWPW-1:0] sw_r, sw_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pt_r    <= '0;
      sw_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pt_r    <= pt_nxt;
      sw_r    <= sw_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pt_nxt    = pt_r;
    sw_nxt    = sw_r;
    cmd       = '0;
    cmd.addr  = pt_r;
    in_ready  = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        cmd.addr = in_data.point_index;
        if (in_valid) begin
          unique case (in_data.command)
            CMD_LOAD: cmd.ld_we = 1'b1;
            CMD_SOLVE: begin
              pt_nxt    = '0;
              state_nxt = S_COPY;
            end
            CMD_READ: state_nxt = S_R1;
            default: ;
          endcase
        end
      end
      S_COPY: begin
        cmd.copy_rd = 1'b1;
        if (pt_r == PT_LAST) begin
          sw_nxt       = '0;
          pt_nxt       = AW'(1);
          cmd.left_clr = 1'b1;
          state_nxt    = (stat.sweep_count == '0) ? S_DONE : S_PA;
        end else begin
          pt_nxt = pt_r + 1'b1;
        end
      end
      S_PA: state_nxt = S_PB;
      S_PB: begin
        cmd.addr  = pt_r - 1'b1;
        cmd.cap_c = 1'b1;
        state_nxt = S_PC;
      end
      S_PC: begin
        cmd.addr  = pt_r + 1'b1;
        cmd.cap_m = 1'b1;
        state_nxt = S_PD;
      end
      S_PD: begin
        cmd.cap_p = 1'b1;
        state_nxt = S_PE;
      end
      S_PE: begin
        cmd.calc_w = 1'b1;
        state_nxt  = S_PF;
      end
      S_PF: begin
        cmd.mul_n = 1'b1;
        state_nxt = S_PG;
      end
      S_PG: begin
        cmd.sum_n = 1'b1;
        state_nxt = S_PH;
      end
      S_PH: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        cmd.it_we = 1'b1;
        if (pt_r == PT_END) begin
          if ({1'b0, sw_r} + 9'd1 == {1'b0, stat.sweep_count}) begin
            state_nxt = S_DONE;
          end else begin
            sw_nxt       = sw_r + 1'b1;
            pt_nxt       = AW'(1);
            cmd.left_clr = 1'b1;
            state_nxt    = S_PA;
          end
        end else begin
          pt_nxt    = pt_r + 1'b1;
          state_nxt = S_PA;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_ld_done = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      S_R1: begin
        cmd.rd_sq = 1'b1;
        state_nxt = S_R2;
      end
      S_R2: begin
        if (stat.out_free) begin
          cmd.out_ld_read = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `CNJS_ASSERT_NEXT(a_div_hold, (state_r == S_DIV) && !stat.div_done, state_r == S_DIV)
  `CNJS_ASSERT_NOW(a_pt_interior, state_r == S_PA, (pt_r != '0) && (pt_r <= PT_END))
  `CNJS_ASSERT_NOW(a_sweep_range, state_r == S_WR, sw_r < stat.sweep_count)
  `CNJS_ASSERT_NEXT(a_done_idle, cmd.out_ld_done, state_r == S_IDLE)

endmodule

// ===== rtl/crank_nicolson_jacobi_step.sv =====
// One Crank-Nicolson time step of a 1D complex wave, solved by Jacobi sweeps.
// Input channel (in_valid/in_ready, in_data): load stores potential and wave
//   at a point; solve copies the wave into the iterate and runs sweep_count
//   sweeps over the interior points; read returns a point of the iterate
//   with its squared magnitude. Command 3 is taken and dropped.
// Result channel (out_valid/out_ready, out_data): one item per solve (kind 0)
//   and per read (kind 1), held in an output register until taken.
// Configuration (cfg_we/cfg_index/cfg_data): writes take effect at once; the
//   user must make them only while the block is idle; it does not enforce this.
// A read result is loaded into the output register after the squares are
//   registered. A solve copies every point of the wave, then for each interior
//   point runs the reads and multiply stages, the bit-serial restoring dividers
//   and one write.
// in_ready is high only while no item is being worked on.
// Reset (rst_n, synchronous, active low) restores the register defaults and
//   clears the control state; point memories are undefined until loaded.
// A stalled receiver holds the result in the output register; the block
//   then waits at the end of the next solve or read before taking new items.
module crank_nicolson_jacobi_step (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  cnjs_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cnjs_pkg::out_item_t         out_data,
  input  logic                        cfg_we,
  input  logic [cnjs_pkg::CFG_IW-1:0] cfg_index,
  input  logic [cnjs_pkg::CFG_DW-1:0] cfg_data
);
  import cnjs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  cnjs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .stat     (stat),
    .cmd      (cmd)
  );

  cnjs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/sv/tb_crank_nicolson_jacobi_step.sv =====
// self-checking testbench of the crank-nicolson jacobi step block
module tb_crank_nicolson_jacobi_step;
  timeunit 1ns;
  timeprecision 1ps;
  import cnjs_pkg::*;

  localparam int IDLE_LIMIT = 4_500_000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  class jacobi_predictor;
    int pot_mem[POINTS];
    int psi_re[POINTS];
    int psi_im[POINTS];
    int it_re[POINTS];
    int it_im[POINTS];
    int left_re;
    int left_im;
    longint step_sq;
    longint time_c;
    int sweeps;
    out_item_t pending[$];
    int mismatches;

    function new();
      step_sq = 65536;
      time_c = 13107200;
      sweeps = 20;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] v);
      case (idx)
        CFG_SPACE_STEP_SQ: step_sq = v;
        CFG_TIME_COEF:     time_c = v;
        CFG_SWEEP_COUNT:   sweeps = v[SWPW-1:0];
        default: ;
      endcase
    endfunction

    // end points read as zero
    function int psi_at(int j, bit imag);
      if (j == 0 || j >= POINTS - 1) return 0;
      return imag ? psi_im[j] : psi_re[j];
    endfunction

    function int iter_at(int j, bit imag);
      if (j == 0 || j >= POINTS - 1) return 0;
      return imag ? it_im[j] : it_re[j];
    endfunction

    function longint clamp_coef(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
    endfunction

    // truncating divide to q4.20 with saturation
    function int divide_q(longint num, longint den);
      longint unsigned mag, d, q, r, lim;
      int k;
      mag = (num < 0) ? -num : num;
      d = den;
      q = mag / d;
      r = mag % d;
      lim = 64'd1 << (SW - 1);
      if (q >= (64'd1 << (SW - 1 - (FRAC - 4)))) begin
        q = lim;
      end else begin
        for (k = 0; k < FRAC - 4; k++) begin
          r = r << 1;
          q = q << 1;
          if (r >= d) begin
            r = r - d;
            q = q | 1;
          end
        end
      end
      if (num < 0) return -int'(q > lim ? lim : q);
      return int'(q > lim - 1 ? lim - 1 : q);
    endfunction

    function void sweep_point(int i);
      longint s, ar, br, pr, pim, wr, wi, nr, ni, den;
      int ore, oim;
      s = (step_sq * longint'(pot_mem[i])) >>> CFRAC;
      ar = clamp_coef(-s - (longint'(2) << CFRAC));
      br = clamp_coef(s + (longint'(2) << CFRAC));
      pr = psi_re[i];
      pim = psi_im[i];
      wr = ((br * pr - time_c * pim) >>> CFRAC) - psi_at(i - 1, 0) - psi_at(i + 1, 0);
      wi = ((br * pim + time_c * pr) >>> CFRAC) - psi_at(i - 1, 1) - psi_at(i + 1, 1);
      nr = wr - left_re - iter_at(i + 1, 0);
      ni = wi - left_im - iter_at(i + 1, 1);
      den = ar * ar + time_c * time_c;
      ore = it_re[i];
      oim = it_im[i];
      if (den == 0) begin
        it_re[i] = 0;
        it_im[i] = 0;
      end else begin
        it_re[i] = divide_q(nr * ar + ni * time_c, den);
        it_im[i] = divide_q(ni * ar - nr * time_c, den);
      end
      left_re = ore;
      left_im = oim;
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      longint re, im, dens;
      int i, n;
      r = '0;
      case (it.command)
        CMD_LOAD: begin
          pot_mem[it.point_index] = it.potential;
          psi_re[it.point_index] = it.wave_re;
          psi_im[it.point_index] = it.wave_im;
        end
        CMD_SOLVE: begin
          for (i = 0; i < POINTS; i++) begin
            it_re[i] = psi_at(i, 0);
            it_im[i] = psi_at(i, 1);
          end
          for (n = 0; n < sweeps; n++) begin
            left_re = 0;
            left_im = 0;
            for (i = 1; i < POINTS - 1; i++) sweep_point(i);
          end
          r.kind = KIND_DONE;
          pending.push_back(r);
        end
        CMD_READ: begin
          re = iter_at(it.point_index, 0);
          im = iter_at(it.point_index, 1);
          dens = (re * re + im * im) >>> FRAC;
          if (dens > 24'hFFFFFF) dens = 24'hFFFFFF;
          r.kind = KIND_READ;
          r.out_index = it.point_index;
          r.new_re = re[SW-1:0];
          r.new_im = im[SW-1:0];
          r.density = dens[SW-1:0];
          pending.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      e = pending.pop_front();
      if (got.kind != e.kind)
        report($sformatf("kind exp %0d got %0d", e.kind, got.kind));
      if (got.out_index != e.out_index)
        report($sformatf("index exp %0d got %0d", e.out_index, got.out_index));
      if (got.new_re != e.new_re)
        report($sformatf("re @%0d exp %h got %h", e.out_index, e.new_re, got.new_re));
      if (got.new_im != e.new_im)
        report($sformatf("im @%0d exp %h got %h", e.out_index, e.new_im, got.new_im));
      if (got.density != e.density)
        report($sformatf("density @%0d exp %h got %h", e.out_index, e.density,
                         got.density));
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  jacobi_predictor wave_model;
  bit quiet;
  bit long_hold_req;
  int hold_left = 0;
  int idle_cycles = 0;

  crank_nicolson_jacobi_step DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver with random stall bursts and one long hold-off on request
  always @(posedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      hold_left = $urandom_range(1, 12) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) wave_model.check(out_data);
    if (rst_n && ((in_valid && in_ready) || (out_valid && out_ready))) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("** crank_nicolson_jacobi_step: FAILED **");
        $finish;
      end
    end
  end

  function automatic logic [23:0] rand_val();
    case ($urandom_range(0, 3))
      0: return 24'($urandom());
      1: return 24'($signed($urandom_range(0, 131071)) - 65536);
      2: begin
        case ($urandom_range(0, 3))
          0: return 24'h7FFFFF;
          1: return 24'h800000;
          2: return 24'h000000;
          default: return 24'hFFFFFF;
        endcase
      end
      default: return 24'($signed($urandom_range(0, 2097151)) - 1048576);
    endcase
  endfunction

  task automatic send_item(in_item_t it);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    wave_model.note_input(it);
  endtask

  task automatic send_cmd(logic [1:0] cmd, int idx, logic [23:0] pot,
                          logic [23:0] wr, logic [23:0] wi);
    in_item_t it;
    it.command = cmd;
    it.point_index = idx[AW-1:0];
    it.potential = pot;
    it.wave_re = wr;
    it.wave_im = wi;
    send_item(it);
  endtask

  task automatic send_random(int count, bit allow_solve);
    int k, r;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (allow_solve && r < 2) send_cmd(CMD_SOLVE, $urandom_range(0, 127), rand_val(),
                                         rand_val(), rand_val());
      else if (r < 4) send_cmd(CMD_UNUSED, $urandom_range(0, 127), rand_val(), rand_val(),
                               rand_val());
      else if (r < 50) send_cmd(CMD_LOAD, $urandom_range(0, 127), rand_val(), rand_val(),
                                rand_val());
      else send_cmd(CMD_READ, $urandom_range(0, 127), rand_val(), rand_val(),
                    rand_val());
    end
  endtask

  // wait for every result, then let trailing work settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (wave_model.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    wave_model.set_reg(idx, v);
  endtask

  task automatic set_regs(logic [23:0] h, logic [23:0] tc, logic [7:0] sw);
    write_reg(CFG_SPACE_STEP_SQ, h);
    write_reg(CFG_TIME_COEF, tc);
    write_reg(CFG_SWEEP_COUNT, {16'd0, sw});
    cfg_we <= 1'b0;
  endtask

  initial begin
    int i;
    wave_model = new();
    quiet = 1'b0;
    long_hold_req = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the grid with field extremes, then a first solve at reset settings
    for (i = 0; i < POINTS; i++) begin
      if (i == 1) send_cmd(CMD_LOAD, i, 24'h7FFFFF, 24'h7FFFFF, 24'h800000);
      else if (i == 2) send_cmd(CMD_LOAD, i, 24'h800000, 24'h800000, 24'h7FFFFF);
      else if (i == 0 || i == POINTS - 1)
        send_cmd(CMD_LOAD, i, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
      else send_cmd(CMD_LOAD, i, rand_val(), rand_val(), rand_val());
    end
    send_cmd(CMD_SOLVE, 0, '0, '0, '0);
    send_cmd(CMD_READ, 0, '0, '0, '0);
    send_cmd(CMD_READ, 1, '0, '0, '0);
    send_cmd(CMD_READ, 2, '0, '0, '0);
    send_cmd(CMD_READ, 64, '0, '0, '0);
    send_cmd(CMD_READ, 126, '0, '0, '0);
    send_cmd(CMD_READ, 127, '0, '0, '0);
    send_cmd(CMD_UNUSED, 127, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send_random(250, 1'b1);
    drain();

    // zero imaginary diagonal with potential -2.0 gives a zero divisor
    set_regs(24'd65536, 24'd0, 8'd2);
    send_cmd(CMD_LOAD, 5, 24'hFE0000, 24'h100000, 24'hF00000);
    send_cmd(CMD_SOLVE, 0, '0, '0, '0);
    send_cmd(CMD_READ, 4, '0, '0, '0);
    send_cmd(CMD_READ, 5, '0, '0, '0);
    send_cmd(CMD_READ, 6, '0, '0, '0);
    send_random(250, 1'b1);
    drain();

    // largest coefficients, one sweep, receiver stalls long under a read stream
    set_regs(24'hFFFFFF, 24'hFFFFFF, 8'd1);
    long_hold_req = 1'b1;
    for (i = 0; i < 20; i++) send_cmd(CMD_READ, $urandom_range(0, 127), '0, '0, '0);
    send_random(300, 1'b1);
    drain();

    set_regs(24'd0, 24'd1, 8'd3);
    send_random(250, 1'b1);
    drain();

    // most sweeps: a single long solve
    set_regs(rand_val(), 24'($urandom_range(65536, 16777215)), 8'd255);
    send_cmd(CMD_SOLVE, 0, '0, '0, '0);
    for (i = 0; i < 20; i++) send_cmd(CMD_READ, $urandom_range(0, 127), '0, '0, '0);
    drain();

    set_regs(24'($urandom()), 24'($urandom()), 8'($urandom_range(1, 4)));
    send_random(285, 1'b1);
    quiet = 1'b1;
    send_random(285, 1'b1);
    drain();

    if (wave_model.mismatches == 0 && wave_model.pending.size() == 0) begin
      $display("** crank_nicolson_jacobi_step: PASSED **");
    end else begin
      $display("** crank_nicolson_jacobi_step: FAILED **");
    end
    $finish;
  end
endmodule
